// ----- hw/rtl/sha1_pkg.sv -----
// Package with the shared types and constants of the SHA-1 digest core.
`timescale 1ns / 1ps
package sha1_pkg;
	localparam int QueueDepth = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_OUT
	} back_state_t;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PadByte = 8'h80;
	localparam logic [5:0]  LenStart = 6'd56;
endpackage

// ----- hw/rtl/sha1_if.sv -----
// Valid/ready channel interfaces for the SHA-1 digest core.
`timescale 1ns / 1ps
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha1_front.sv -----
// Front end: accepts transactions, drops empty ones, and queues the rest.
`timescale 1ns / 1ps
module sha1_front (
	input  logic           clk,
	input  logic           arst_n,
	sha1_in_if.sink        in_ch,
	output sha1_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_take
);
	import sha1_pkg::*;

	cmd_t       fifo_q [QueueDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ch.ready = (count_q != 2'(QueueDepth));
	// Items with neither a byte nor an end mark change nothing, so they never enter the queue.
	assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_valid && cmd_take;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'(QueueDepth))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !cmd_valid |=> !pop || $past(push))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(QueueDepth)) |-> !in_ch.ready)
		else $error("ready while full");
endmodule

// ----- hw/rtl/sha1_back.sv -----
// Back end: block packing, padding, 80-round compression and digest output.
`timescale 1ns / 1ps
module sha1_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sha1_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_take,
	sha1_out_if.source     out_ch
);
	import sha1_pkg::*;

	back_state_t state_q, state_d;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  fill_q;
	logic [60:0] bytes_q;
	logic [6:0]  round_q;
	logic        final_q;   // the running compression is the last of the message
	logic        pad_more_q; // after this compression, a length block still follows
	logic [2:0]  oidx_q;

	logic        start_round;
	logic        start_pad;
	logic [31:0] wn, f, k, t, wi;
	logic [63:0] bits;
	logic [5:0]  fill_eff;
	logic [60:0] bytes_eff;
	logic [63:0] bits_eff;

	assign bits = {bytes_q, 3'b000};
	// Fill and length once the closing transaction's own byte is counted.
	assign fill_eff = fill_q + 6'(cmd.has_byte);
	assign bytes_eff = bytes_q + 61'(cmd.has_byte);
	assign bits_eff = {bytes_eff, 3'b000};
	assign wi = (round_q < 7'd16) ? w_q[round_q[3:0]] :
		{wn[30:0], wn[31]};
	assign wn = w_q[4'(round_q[3:0] - 4'd3)] ^ w_q[4'(round_q[3:0] - 4'd8)]
		^ w_q[4'(round_q[3:0] - 4'd14)] ^ w_q[round_q[3:0]];

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wi;
	end

	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		start_round = 1'b0;
		start_pad = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					if (cmd.has_byte && fill_q == 6'd63) begin
						start_round = 1'b1;
						state_d = ST_ROUND;
					end else if (cmd.end_of_message) begin
						start_pad = 1'b1;
						start_round = 1'b1;
						state_d = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				start_round = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == 7'd79) begin
					if (pad_more_q) state_d = ST_PAD;
					else if (final_q) state_d = ST_OUT;
					else state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ch.ready && oidx_q == 3'd4) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.digest_word = h_q[oidx_q];
	assign out_ch.word_index = oidx_q;
	assign out_ch.last_word = (oidx_q == 3'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Byte packing, padding and the round datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_take && cmd.has_byte) begin
			w_q[fill_q[5:2]][5'd31 - {fill_q[1:0], 3'b000} -: 8] <= cmd.data_byte;
		end
		if (start_pad) begin
			// Place 0x80 after the pending bytes and zero the rest.
			for (int j = 0; j < 16; j++) begin
				for (int bb = 0; bb < 4; bb++) begin
					if (6'(j * 4 + bb) == fill_eff)
						w_q[j][31 - bb * 8 -: 8] <= PadByte;
					else if (6'(j * 4 + bb) > fill_eff)
						w_q[j][31 - bb * 8 -: 8] <= 8'h00;
				end
			end
			if (fill_eff < LenStart) begin
				w_q[14] <= bits_eff[63:32];
				w_q[15] <= bits_eff[31:0];
			end
		end
		if (state_q == ST_PAD) begin
			// Length-only block; it also carries the 0x80 mark when the message
			// ended exactly on a block boundary.
			for (int j = 0; j < 16; j++) w_q[j] <= 32'd0;
			w_q[0] <= (bytes_q[5:0] == 6'd0) ? {PadByte, 24'd0} : 32'd0;
			w_q[14] <= bits[63:32];
			w_q[15] <= bits[31:0];
		end
		if (start_round) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			if (round_q >= 7'd16) w_q[round_q[3:0]] <= wi;
			a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			fill_q <= 6'd0;
			bytes_q <= 61'd0;
			round_q <= 7'd0;
			final_q <= 1'b0;
			pad_more_q <= 1'b0;
			oidx_q <= 3'd0;
		end else begin
			if (state_q == ST_IDLE && cmd_take) begin
				if (cmd.has_byte) begin
					fill_q <= fill_q + 6'd1;
					bytes_q <= bytes_q + 61'd1;
				end
				final_q <= cmd.end_of_message;
				// A full block with an end mark still needs a pad-only block.
				pad_more_q <= cmd.has_byte && fill_q == 6'd63 && cmd.end_of_message;
			end
			if (start_pad) pad_more_q <= (fill_eff >= LenStart);
			if (state_q == ST_PAD) pad_more_q <= 1'b0;
			if (state_q == ST_ROUND) begin
				if (round_q == 7'd79) begin
					round_q <= 7'd0;
					h_q[0] <= h_q[0] + t;
					h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
					h_q[3] <= h_q[3] + c_q;
					h_q[4] <= h_q[4] + d_q;
					fill_q <= 6'd0;
				end else begin
					round_q <= round_q + 7'd1;
				end
			end
			if (state_q == ST_OUT && out_ch.ready) begin
				if (oidx_q == 3'd4) begin
					oidx_q <= 3'd0;
					h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
					bytes_q <= 61'd0;
					final_q <= 1'b0;
				end else begin
					oidx_q <= oidx_q + 3'd1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(oidx_q))
		else $error("digest word dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n) oidx_q <= 3'd4)
		else $error("word index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (round_q == 7'd0))
		else $error("round counter active outside compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> (state_q == ST_IDLE))
		else $error("command taken while busy");
endmodule

// ----- hw/rtl/sha1_message_digest_core.sv -----
// Top level of the byte-serial SHA-1 message digest core.
`timescale 1ns / 1ps
// Usage:
// The input channel carries one transaction per message byte: data_byte with
// has_byte set, and end_of_message set on the transaction that closes the
// message (it may carry a byte too, or none, so an empty message works).
// Transactions with neither flag are dropped at once.
// A two-entry queue separates the front end from the compression engine, so
// the source keeps pushing bytes while the engine works.
// While idle, the engine takes a queued byte whenever one is present; each 64th
// byte starts a compression in the single round unit, during which none is taken.
// The closing transaction builds the padded block, and a compression follows;
// when the length does not fit, a padding step builds a length-only block and
// another compression follows. Then, while the receiver is ready, the five
// digest words leave one per cycle on the output channel, word 0 first, and
// last_word marks word 4. When the receiver stalls, the current digest word
// holds and the engine waits; the queue fills and the input ready drops.
// Reset loads the initial hash words, clears counts and empties the queue.
// After the last digest word the core is ready for a new message.
module sha1_message_digest_core (
	input  logic       clk,
	input  logic       arst_n,
	sha1_in_if.sink    in_ch,
	sha1_out_if.source out_ch
);
	import sha1_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	sha1_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
	);

	sha1_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .out_ch(out_ch)
	);
endmodule
